/* src/gpe_pkg.sv */
// Shared types and constants for the gear position estimator.
package gpe_pkg;

  localparam int GEAR_CNT      = 6;
  localparam int LEARN_SAMPLES = 25;
  localparam int RATIO_WIDTH   = 24;

  localparam int GEAR_W = 4;
  localparam logic [GEAR_W-1:0] GEAR_UNKNOWN = 4'd15;
  localparam logic FUNC_BAND = 1'b1;

  localparam logic [2:0] CFG_LEARN_ENABLE   = 3'd0;
  localparam logic [2:0] CFG_MIN_RPM        = 3'd1;
  localparam logic [2:0] CFG_MIN_SPEED      = 3'd2;
  localparam logic [2:0] CFG_BAND_TOLERANCE = 3'd3;
  localparam logic [2:0] CFG_DEBOUNCE_COUNT = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RDIV,
    ST_LSTEP,
    ST_LCHK,
    ST_DUP,
    ST_LSTORE,
    ST_CLS_A,
    ST_CLS_B,
    ST_CLS_END,
    ST_DEB,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic band_wr;
    logic raw_direct;
    logic div_start;
    logic ratio_ld;
    logic learn_step;
    logic centre_ld;
    logic walk_clr;
    logic walk_inc;
    logic dup_chk;
    logic learn_store;
    logic cls_a;
    logic cls_b;
    logic cls_end;
    logic deb;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic ratio_path;
    logic learn_en;
    logic learn_full;
    logic div_busy;
    logic div_done;
    logic walk_last;
    logic out_busy;
  } status_t;

endpackage

/* src/gear_position_estimator.sv */
// Gear position estimator top level: one request in flight, one result per request.
// Paths: band write; neutral/register path; ratio path through the bit-serial
// rpm/speed divider. Learning enabled adds the learn step and check on the ratio path;
// a completed run adds a duplicate walk over the GEAR_CNT bands and a store.
// A new request is taken only once the last result is loaded; held while the result waits.
// Synchronous active-low reset clears control, config to defaults, all bands invalid.
module gear_position_estimator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [13:0]       in_rpm,
  input  logic [15:0]       in_speed,
  input  logic              in_sample_valid,
  input  logic              in_neutral_switch,
  input  logic signed [7:0] in_gear_reg,
  input  logic [2:0]        in_band_index,
  input  logic [23:0]       in_band_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_gear,
  output logic              out_gear_known
);
  import gpe_pkg::*;

  cmd_t    cmd;
  status_t status;

  gpe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gpe_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_func           (in_func),
    .in_rpm            (in_rpm),
    .in_speed          (in_speed),
    .in_sample_valid   (in_sample_valid),
    .in_neutral_switch (in_neutral_switch),
    .in_gear_reg       (in_gear_reg),
    .in_band_index     (in_band_index),
    .in_band_value     (in_band_value),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_gear          (out_gear),
    .out_gear_known    (out_gear_known)
  );

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !status.div_busy)
    else $error("divider restarted while busy");

  a_known_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_gear_known) |=> (!out_valid || out_gear_known))
    else $error("gear_known dropped");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> !status.out_busy)
    else $error("result overwritten");

endmodule

/* src/gpe_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module gpe_div #(
  parameter int DDW = 30,
  parameter int DVW = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DDW-1:0] dividend,
  input  logic [DVW-1:0] divisor,
  output logic           busy,
  output logic           done,
  output logic [DDW-1:0] quotient
);

  localparam int CW = (DDW > 1) ? $clog2(DDW) : 1;

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DVW-1:0] rem_r;
  logic [DDW-1:0] quo_r;
  logic [DVW-1:0] dvs_r;
  logic [DVW:0]   shifted;
  logic [DVW:0]   diff;
  logic           ge;

  assign shifted = {rem_r, quo_r[DDW-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DDW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVW-1:0] : shifted[DVW-1:0];
      quo_r <= {quo_r[DDW-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* src/gpe_dp.sv */
// Datapath: config, item capture, ratio, learning, band walk, debounce, output.
module gpe_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gpe_pkg::cmd_t          cmd,
  output gpe_pkg::status_t       status,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   in_func,
  input  logic [13:0]            in_rpm,
  input  logic [15:0]            in_speed,
  input  logic                   in_sample_valid,
  input  logic                   in_neutral_switch,
  input  logic signed [7:0]      in_gear_reg,
  input  logic [2:0]             in_band_index,
  input  logic [23:0]            in_band_value,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [2:0]             out_gear,
  output logic                   out_gear_known
);
  import gpe_pkg::*;

  localparam int RW    = RATIO_WIDTH;
  localparam int CNTW  = $clog2(LEARN_SAMPLES + 1);
  localparam int SUMW  = RW + CNTW;
  localparam int DDW   = 14 + 16;
  localparam int DVW   = 16;
  localparam int IW    = (GEAR_CNT > 1) ? $clog2(GEAR_CNT) : 1;
  localparam int LOG_L = (LEARN_SAMPLES > 1) ? $clog2(LEARN_SAMPLES) : 1;
  localparam int RSH   = SUMW + LOG_L;
  localparam int RCW   = SUMW + 1;
  localparam logic [RCW-1:0] RECIP =
    RCW'(((64'd1 << RSH) + 64'(LEARN_SAMPLES) - 64'd1) / 64'(LEARN_SAMPLES));

  // configuration
  logic        learn_en_r;
  logic [13:0] min_rpm_r;
  logic [15:0] min_speed_r;
  logic [7:0]  tol_r;
  logic [3:0]  deb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_en_r  <= 1'b0;
      min_rpm_r   <= 14'd600;
      min_speed_r <= 16'd768;
      tol_r       <= 8'd36;
      deb_r       <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEARN_ENABLE:   learn_en_r  <= cfg_data[0];
        CFG_MIN_RPM:        min_rpm_r   <= cfg_data[13:0];
        CFG_MIN_SPEED:      min_speed_r <= cfg_data;
        CFG_BAND_TOLERANCE: tol_r       <= cfg_data[7:0];
        CFG_DEBOUNCE_COUNT: deb_r       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // captured request
  logic        func_r, svalid_r, neutral_r;
  logic [13:0] rpm_r;
  logic [15:0] speed_r;
  logic [7:0]  greg_r;
  logic [2:0]  bidx_r;
  logic [23:0] bval_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r    <= in_func;
      rpm_r     <= in_rpm;
      speed_r   <= in_speed;
      svalid_r  <= in_sample_valid;
      neutral_r <= in_neutral_switch;
      greg_r    <= in_gear_reg;
      bidx_r    <= in_band_index;
      bval_r    <= in_band_value;
    end
  end

  logic              greg_ok, usable;
  logic [GEAR_W-1:0] direct_raw;

  assign greg_ok    = !greg_r[7] && (greg_r <= 8'(GEAR_CNT));
  assign usable     = svalid_r && (rpm_r >= min_rpm_r) && (speed_r >= min_speed_r);
  assign direct_raw = neutral_r ? GEAR_W'(0) : (greg_ok ? greg_r[GEAR_W-1:0] : GEAR_UNKNOWN);

  // divider
  logic [SUMW-1:0] sum_r;
  logic [CNTW-1:0] cnt_r;
  logic [DDW-1:0]  div_dividend, quo;
  logic [DVW-1:0]  div_divisor;
  logic            div_busy, div_done;

  assign div_dividend = {rpm_r, 16'h0000};
  assign div_divisor  = speed_r;

  gpe_div #(.DDW(DDW), .DVW(DVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  logic [RW-1:0] ratio_r, last_r, centre_r;
  logic [RW-1:0] diff_last;
  logic [RW+3:0] diff10;
  logic          jump;
  logic [SUMW+RCW-1:0] cprod;

  assign diff_last = (ratio_r > last_r) ? ratio_r - last_r : last_r - ratio_r;
  assign diff10    = ({4'b0, diff_last} << 3) + ({4'b0, diff_last} << 1);
  assign jump      = (cnt_r != '0) && (diff10 > (RW+4)'(last_r));
  // sum / LEARN_SAMPLES by reciprocal multiplication, exact over the sum range
  assign cprod     = sum_r * RECIP;

  always_ff @(posedge clk) begin
    if (cmd.ratio_ld)
      ratio_r <= (|quo[DDW-1:RW]) ? '1 : quo[RW-1:0];
    if (cmd.centre_ld)
      centre_r <= cprod[RSH +: RW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      last_r <= '0;
    end else if (cmd.learn_step) begin
      last_r <= ratio_r;
      if (jump) begin
        sum_r <= SUMW'(ratio_r);
        cnt_r <= CNTW'(1);
      end else begin
        sum_r <= sum_r + SUMW'(ratio_r);
        cnt_r <= cnt_r + CNTW'(1);
      end
    end else if (cmd.centre_ld) begin
      sum_r <= '0;
      cnt_r <= '0;
    end
  end

  // band store and walk
  logic [RW-1:0]        band_r [GEAR_CNT];
  logic [GEAR_CNT-1:0]  bvalid_r;
  logic [IW-1:0]        idx_r, fe_idx;
  logic [RW-1:0]        b;
  logic [RW-1:0]        cdiff, num;
  logic [RW+4:0]        d25;
  logic                 dup_r, dup_hit, any_empty, elig;

  assign b       = band_r[idx_r];
  assign cdiff   = (centre_r > b) ? centre_r - b : b - centre_r;
  assign d25     = ({5'b0, cdiff} << 4) + ({5'b0, cdiff} << 3) + {5'b0, cdiff};
  assign dup_hit = bvalid_r[idx_r] && (d25 < (RW+5)'({b, 1'b0}));
  assign any_empty = ~&bvalid_r;
  assign num     = (ratio_r > b) ? ratio_r - b : b - ratio_r;
  assign elig    = bvalid_r[idx_r] && (b != '0);

  always_comb begin
    fe_idx = '0;
    for (int g = GEAR_CNT - 1; g >= 0; g--) begin
      if (!bvalid_r[g]) fe_idx = IW'(g);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= '0;
    end else if (cmd.band_wr && bidx_r != 3'd0 && ({1'b0, bidx_r} <= 4'(GEAR_CNT))) begin
      bvalid_r[IW'(bidx_r - 3'd1)] <= 1'b1;
    end else if (cmd.learn_store && any_empty && !dup_r) begin
      bvalid_r[fe_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.band_wr && bidx_r != 3'd0 && ({1'b0, bidx_r} <= 4'(GEAR_CNT)))
      band_r[IW'(bidx_r - 3'd1)] <= RW'(bval_r);
    else if (cmd.learn_store && any_empty && !dup_r)
      band_r[fe_idx] <= centre_r;
  end

  // classifier
  logic [RW-1:0]   best_num_r, best_den_r, ma, mb;
  logic [IW-1:0]   best_idx_r;
  logic            found_r;
  logic [2*RW-1:0] prod, prod_r;
  logic [RW+7:0]   tol_lhs, tol_rhs;
  logic [GEAR_W-1:0] raw_r;

  assign ma      = cmd.cls_b ? best_num_r : num;
  assign mb      = cmd.cls_b ? b : best_den_r;
  assign prod    = ma * mb;
  assign tol_lhs = {best_num_r, 8'h00};
  assign tol_rhs = tol_r * best_den_r;

  always_ff @(posedge clk) begin
    if (cmd.walk_clr) begin
      idx_r   <= '0;
      dup_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (cmd.walk_inc) idx_r <= idx_r + IW'(1);
      if (cmd.dup_chk && dup_hit) dup_r <= 1'b1;
      if (cmd.cls_b && elig && (!found_r || prod_r < prod)) begin
        found_r    <= 1'b1;
        best_idx_r <= idx_r;
        best_num_r <= num;
        best_den_r <= b;
      end
    end
    if (cmd.cls_a) prod_r <= prod;
    if (cmd.raw_direct)
      raw_r <= direct_raw;
    else if (cmd.cls_end)
      raw_r <= (found_r && tol_lhs <= tol_rhs) ? GEAR_W'(best_idx_r) + GEAR_W'(1)
                                               : GEAR_UNKNOWN;
  end

  // debounce
  logic [GEAR_W-1:0] cand_r;
  logic [3:0]        stab_r, stab_nxt;
  logic [2:0]        com_r;
  logic              known_r;

  assign stab_nxt = (raw_r == cand_r) ? ((stab_r < deb_r) ? stab_r + 4'd1 : stab_r) : 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r  <= GEAR_UNKNOWN;
      stab_r  <= '0;
      com_r   <= '0;
      known_r <= 1'b0;
    end else if (cmd.deb) begin
      cand_r <= raw_r;
      stab_r <= stab_nxt;
      if (stab_nxt >= deb_r && raw_r != GEAR_UNKNOWN) begin
        com_r   <= raw_r[2:0];
        known_r <= 1'b1;
      end
    end
  end

  // result register
  logic       out_valid_r;
  logic [2:0] out_gear_r;
  logic       out_known_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_gear_r  <= com_r;
      out_known_r <= known_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_gear       = out_gear_r;
  assign out_gear_known = out_known_r;

  assign status.func       = (func_r == FUNC_BAND);
  assign status.ratio_path = !neutral_r && !greg_ok && usable;
  assign status.learn_en   = learn_en_r;
  assign status.learn_full = cnt_r >= CNTW'(LEARN_SAMPLES);
  assign status.div_busy   = div_busy;
  assign status.div_done   = div_done;
  assign status.walk_last  = idx_r == IW'(GEAR_CNT - 1);
  assign status.out_busy   = out_valid_r && !out_ready;

endmodule

/* src/gpe_ctrl.sv */
// Controller state machine sequencing the estimator datapath.
module gpe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gpe_pkg::status_t status,
  output gpe_pkg::cmd_t    cmd
);
  import gpe_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (status.func)            state_nxt = ST_OUT;
        else if (status.ratio_path) state_nxt = ST_RDIV;
        else                        state_nxt = ST_DEB;
      end
      ST_RDIV:    if (status.div_done) state_nxt = status.learn_en ? ST_LSTEP : ST_CLS_A;
      ST_LSTEP:   state_nxt = ST_LCHK;
      ST_LCHK:    state_nxt = status.learn_full ? ST_DUP : ST_CLS_A;
      ST_DUP:     if (status.walk_last) state_nxt = ST_LSTORE;
      ST_LSTORE:  state_nxt = ST_CLS_A;
      ST_CLS_A:   state_nxt = ST_CLS_B;
      ST_CLS_B:   state_nxt = status.walk_last ? ST_CLS_END : ST_CLS_A;
      ST_CLS_END: state_nxt = ST_DEB;
      ST_DEB:     state_nxt = ST_OUT;
      ST_OUT:     if (!status.out_busy) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DECIDE: begin
        if (status.func) begin
          cmd.band_wr = 1'b1;
        end else if (status.ratio_path) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.raw_direct = 1'b1;
        end
      end
      ST_RDIV: begin
        if (status.div_done) begin
          cmd.ratio_ld = 1'b1;
          cmd.walk_clr = !status.learn_en;
        end
      end
      ST_LSTEP: cmd.learn_step = 1'b1;
      ST_LCHK: begin
        cmd.centre_ld = status.learn_full;
        cmd.walk_clr  = 1'b1;
      end
      ST_DUP: begin
        cmd.dup_chk  = 1'b1;
        cmd.walk_inc = !status.walk_last;
      end
      ST_LSTORE: begin
        cmd.learn_store = 1'b1;
        cmd.walk_clr    = 1'b1;
      end
      ST_CLS_A: cmd.cls_a = 1'b1;
      ST_CLS_B: begin
        cmd.cls_b    = 1'b1;
        cmd.walk_inc = !status.walk_last;
      end
      ST_CLS_END: cmd.cls_end = 1'b1;
      ST_DEB:     cmd.deb = 1'b1;
      ST_OUT:     cmd.out_ld = !status.out_busy;
      default: ;
    endcase
  end

endmodule

/* tb/gear_position_estimator_tb.sv */
// Self-checking testbench for the gear position estimator: predicts the committed gear per request.
module gear_position_estimator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gpe_pkg::*;

  localparam int NG = GEAR_CNT;
  localparam int LSAMP = LEARN_SAMPLES;
  localparam logic [23:0] RMAX = 24'hFFFFFF;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        func;
    logic [13:0] rpm;
    logic [15:0] speed;
    logic        sample_valid;
    logic        neutral_switch;
    logic [7:0]  gear_reg;
    logic [2:0]  band_index;
    logic [23:0] band_value;
  } req_t;

  typedef struct packed {
    logic [2:0] gear;
    logic       known;
  } gear_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic [13:0] in_rpm = '0;
  logic [15:0] in_speed = '0;
  logic in_sample_valid = 1'b0;
  logic in_neutral_switch = 1'b0;
  logic signed [7:0] in_gear_reg = '0;
  logic [2:0] in_band_index = '0;
  logic [23:0] in_band_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_gear;
  logic out_gear_known;

  gear_position_estimator i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [23:0] bands [NG];
  logic        band_ok [NG];
  logic [3:0]  cand;
  logic [3:0]  stable;
  logic [2:0]  committed;
  logic        known;
  logic [28:0] lsum;
  logic [4:0]  lcount;
  logic [23:0] llast;
  logic        c_learn;
  logic [13:0] c_min_rpm;
  logic [15:0] c_min_speed;
  logic [7:0]  c_tol;
  logic [3:0]  c_deb;

  req_t      pending_reqs[$];
  gear_out_t expected_gears[$];
  int  errors = 0;
  int  idle_cycles = 0;

  function automatic logic [63:0] adiff(logic [63:0] a, logic [63:0] b);
    return a > b ? a - b : b - a;
  endfunction

  task automatic learn_ratio(logic [23:0] r);
    logic [63:0] centre;
    bit dup;
    if (lcount > 0 && adiff(r, llast) * 10 > llast) begin
      lsum = 0;
      lcount = 0;
    end
    llast = r;
    lsum = lsum + r;
    lcount = lcount + 1;
    if (lcount >= LSAMP) begin
      centre = lsum / lcount;
      for (int g = 0; g < NG; g++) begin
        if (!band_ok[g]) begin
          dup = 0;
          for (int h = 0; h < NG; h++)
            if (band_ok[h] && adiff(centre, bands[h]) * 25 < 2 * 64'(bands[h])) dup = 1;
          if (!dup) begin
            bands[g] = centre[23:0];
            band_ok[g] = 1;
          end
          break;
        end
      end
      lsum = 0;
      lcount = 0;
    end
  endtask

  function automatic logic [3:0] classify_ratio(logic [23:0] r);
    int best;
    logic [63:0] bnum, bden, c, num;
    best = -1;
    bnum = 0;
    bden = 1;
    for (int g = 0; g < NG; g++) begin
      if (!band_ok[g] || bands[g] == 0) continue;
      c = bands[g];
      num = adiff(r, c);
      if (best < 0 || num * bden < bnum * c) begin
        best = g;
        bnum = num;
        bden = c;
      end
    end
    if (best < 0) return GEAR_UNKNOWN;
    if (bnum * 256 <= 64'(c_tol) * bden) return 4'(best + 1);
    return GEAR_UNKNOWN;
  endfunction

  task automatic predict_gear(req_t q);
    logic [3:0] raw;
    logic [63:0] r;
    bit usable;
    if (q.func == FUNC_BAND) begin
      if (q.band_index >= 1 && q.band_index <= NG) begin
        bands[q.band_index - 1] = q.band_value;
        band_ok[q.band_index - 1] = 1;
      end
    end else begin
      if (q.neutral_switch) raw = 0;
      else if (q.gear_reg < 128 && q.gear_reg <= NG) raw = q.gear_reg[3:0];
      else begin
        usable = q.sample_valid && q.rpm >= c_min_rpm && q.speed >= c_min_speed;
        if (q.speed == 0) r = RMAX;
        else begin
          r = (64'(q.rpm) << 16) / q.speed;
          if (r > RMAX) r = RMAX;
        end
        if (usable && c_learn) learn_ratio(r[23:0]);
        raw = usable ? classify_ratio(r[23:0]) : GEAR_UNKNOWN;
      end
      if (raw == cand) begin
        if (stable < c_deb) stable = stable + 1;
      end else begin
        cand = raw;
        stable = 1;
      end
      if (stable >= c_deb && cand != GEAR_UNKNOWN) begin
        committed = cand[2:0];
        known = 1;
      end
    end
    expected_gears.push_back('{gear: committed, known: known});
  endtask

  // driver: bursts and gaps
  int gap = 0;
  int burst = 0;
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      predict_gear(pending_reqs.pop_front());
    end
    if (!(in_valid && !in_ready)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > (in_valid && in_ready ? 0 : 0) &&
                   pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        in_func <= pending_reqs[0].func;
        in_rpm <= pending_reqs[0].rpm;
        in_speed <= pending_reqs[0].speed;
        in_sample_valid <= pending_reqs[0].sample_valid;
        in_neutral_switch <= pending_reqs[0].neutral_switch;
        in_gear_reg <= pending_reqs[0].gear_reg;
        in_band_index <= pending_reqs[0].band_index;
        in_band_value <= pending_reqs[0].band_value;
        if (burst > 0) burst <= burst - 1;
        else begin
          burst <= $urandom_range(0, 12);
          gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
        end
      end else in_valid <= 1'b0;
    end
  end

  // monitor and receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (expected_gears.size() == 0) begin
        $error("unexpected result gear=%0d known=%0b", out_gear, out_gear_known);
        errors++;
      end else begin
        gear_out_t e;
        e = expected_gears.pop_front();
        if (out_gear !== e.gear) begin
          $error("gear: expected %0d actual %0d", e.gear, out_gear);
          errors++;
        end
        if (out_gear_known !== e.known) begin
          $error("gear_known: expected %0b actual %0b", e.known, out_gear_known);
          errors++;
        end
      end
    end
    stall_phase <= (stall_phase + 1) % 53;
    out_ready <= (stall_phase < 20) ? 1'b1 : (stall_phase < 30) ? 1'b0 :
                 ($urandom_range(0, 3) != 0);
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic req_t band_req(logic [2:0] idx, logic [23:0] v);
    req_t q;
    q = '0;
    q.func = FUNC_BAND;
    q.band_index = idx;
    q.band_value = v;
    q.rpm = 14'($urandom);
    q.speed = 16'($urandom);
    q.gear_reg = 8'($urandom);
    q.sample_valid = 1'($urandom);
    q.neutral_switch = 1'($urandom);
    return q;
  endfunction

  function automatic req_t sample_req(logic [13:0] rpm, logic [15:0] spd, logic sv,
                                      logic neu, logic [7:0] greg);
    req_t q;
    q.func = 1'b0;
    q.rpm = rpm;
    q.speed = spd;
    q.sample_valid = sv;
    q.neutral_switch = neu;
    q.gear_reg = greg;
    q.band_index = 3'($urandom);
    q.band_value = 24'($urandom);
    return q;
  endfunction

  function automatic req_t random_sample();
    int k;
    logic [7:0] greg;
    k = $urandom_range(0, 9);
    greg = (k < 6) ? 8'($urandom_range(7, 255)) : (k < 8) ? 8'($urandom_range(0, 6))
                                                          : 8'($urandom);
    return sample_req(($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 7000)),
                      ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 40000)),
                      $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0, greg);
  endfunction

  task automatic write_cfg(logic [2:0] idx, logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LEARN_ENABLE:   c_learn = v[0];
      CFG_MIN_RPM:        c_min_rpm = v[13:0];
      CFG_MIN_SPEED:      c_min_speed = v;
      CFG_BAND_TOLERANCE: c_tol = v[7:0];
      CFG_DEBOUNCE_COUNT: c_deb = v[3:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_gears.size() > 0 || in_valid) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  initial begin
    logic [13:0] rpm;
    logic [15:0] spd;
    for (int g = 0; g < NG; g++) begin
      bands[g] = 0;
      band_ok[g] = 0;
    end
    cand = GEAR_UNKNOWN;
    stable = 0;
    committed = 0;
    known = 0;
    lsum = 0;
    lcount = 0;
    llast = 0;
    c_learn = 0;
    c_min_rpm = 600;
    c_min_speed = 768;
    c_tol = 36;
    c_deb = 3;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: classify with no bands, register path, neutral, band writes, extremes
    pending_reqs.push_back(sample_req(3000, 3000, 1, 0, 8'hFF));
    pending_reqs.push_back(sample_req(0, 0, 0, 0, 8'h80));
    pending_reqs.push_back(sample_req(14'h3FFF, 16'hFFFF, 1, 1, 8'h7F));
    pending_reqs.push_back(sample_req(14'h3FFF, 16'hFFFF, 1, 1, 8'h00));
    pending_reqs.push_back(sample_req(14'h3FFF, 16'hFFFF, 1, 1, 8'h00));
    for (int i = 0; i < 3; i++) pending_reqs.push_back(sample_req(0, 0, 1, 0, 8'd6));
    pending_reqs.push_back(band_req(0, 24'h123456));
    pending_reqs.push_back(band_req(7, 24'hFFFFFF));
    pending_reqs.push_back(band_req(1, 24'h0));
    pending_reqs.push_back(band_req(2, 24'd65536));
    pending_reqs.push_back(band_req(3, 24'd32768));
    pending_reqs.push_back(band_req(6, 24'hFFFFFF));
    for (int i = 0; i < 3; i++) pending_reqs.push_back(sample_req(4000, 4000, 1, 0, 8'h90));
    for (int i = 0; i < 3; i++) pending_reqs.push_back(sample_req(2000, 4000, 1, 0, 8'd7));
    pending_reqs.push_back(sample_req(14'h3FFF, 16'd0, 1, 0, 8'hF0));
    pending_reqs.push_back(sample_req(14'h3FFF, 16'd800, 0, 0, 8'hF0));
    pending_reqs.push_back(sample_req(599, 800, 1, 0, 8'hF0));
    pending_reqs.push_back(sample_req(700, 767, 1, 0, 8'hF0));
    drain();

    // learning with steady ratios, several configurations
    write_cfg(CFG_LEARN_ENABLE, 1);
    write_cfg(CFG_MIN_RPM, 0);
    write_cfg(CFG_MIN_SPEED, 0);
    write_cfg(CFG_BAND_TOLERANCE, 255);
    write_cfg(CFG_DEBOUNCE_COUNT, 1);
    for (int run = 0; run < 6; run++) begin
      spd = 16'($urandom_range(2000, 20000));
      rpm = 14'($urandom_range(800, 6000));
      for (int i = 0; i < 27; i++)
        pending_reqs.push_back(sample_req(rpm + 14'($urandom_range(0, 20)), spd, 1, 0,
                                          8'($urandom_range(7, 255))));
      if (run == 3) pending_reqs.push_back(random_sample());
    end
    drain();

    write_cfg(CFG_DEBOUNCE_COUNT, 0);
    write_cfg(CFG_BAND_TOLERANCE, 0);
    for (int i = 0; i < 60; i++) pending_reqs.push_back(random_sample());
    drain();

    write_cfg(CFG_DEBOUNCE_COUNT, 15);
    write_cfg(CFG_BAND_TOLERANCE, 36);
    write_cfg(CFG_MIN_RPM, 16383);
    write_cfg(CFG_MIN_SPEED, 65535);
    for (int i = 0; i < 60; i++) pending_reqs.push_back(random_sample());
    drain();

    write_cfg(CFG_LEARN_ENABLE, 0);
    write_cfg(CFG_MIN_RPM, 600);
    write_cfg(CFG_MIN_SPEED, 768);
    write_cfg(CFG_DEBOUNCE_COUNT, 3);
    write_cfg(CFG_BAND_TOLERANCE, 60);
    for (int i = 0; i < 80; i++) begin
      if ($urandom_range(0, 15) == 0)
        pending_reqs.push_back(band_req(3'($urandom), 24'($urandom)));
      else if ($urandom_range(0, 3) == 0) begin
        rpm = 14'($urandom_range(700, 8000));
        spd = 16'($urandom_range(1000, 30000));
        for (int k = 0; k < 4; k++) pending_reqs.push_back(sample_req(rpm, spd, 1, 0, 8'hC0));
      end else pending_reqs.push_back(random_sample());
    end
    drain();

    if (errors == 0 && expected_gears.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
